FILE: sv/ptst_pkg.sv
package ptst_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int TIMER_W = 16;
   localparam int ENTRY_W = 2 * TIMER_W;
   localparam int SLOT_W = 4;
   localparam int MASK_W = 16;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_REGISTER = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_ACK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_INACTIVE = 2'd2
   } status_type;

endpackage

FILE: sv/ptst_if.sv
interface ptst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] period;
   logic [3:0]  slot;

   modport source (output valid, command, period, slot, input ready);
   modport sink (input valid, command, period, slot, output ready);
endinterface

interface ptst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  result_slot;
   logic [1:0]  status;
   logic [15:0] pending_mask;

   modport source (output valid, result_slot, status, pending_mask, input ready);
   modport sink (input valid, result_slot, status, pending_mask, output ready);
endinterface

FILE: sv/ptst_ram.sv
module ptst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/periodic_timer_slot_table.sv
// Remove and acknowledge go from idle straight to the result state; register probes
// from the probe start (one slot probed per cycle); tick sweeps all slots (one
// period/countdown RAM entry read and written back per cycle) and then drains.
// One command is in work at a time; the next is taken the cycle after the result
// is registered, which waits while the previous result is held by the receiver.
// Reset (synchronous) clears active and pending bits, probe start and handshakes;
// the RAM is not cleared, an entry is only used while its slot is active.
module periodic_timer_slot_table
   import ptst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ptst_req_if.sink   req_ch,
   ptst_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_DRAIN,
      ST_PROBE,
      ST_RESP
   } state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   state_type             state_ff, state_in;
   logic [SLOT_COUNT-1:0] active_ff, active_in;
   logic [SLOT_COUNT-1:0] pending_ff, pending_in;
   logic [IDX_W-1:0]      probe_start_ff, probe_start_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  wb_vld_ff, wb_vld_in;
   logic [IDX_W-1:0]      wb_addr_ff, wb_addr_in;
   logic [TIMER_W-1:0]    period_ff, period_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0]    ram_wr_data;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [TIMER_W-1:0]    rd_period;
   logic [TIMER_W-1:0]    rd_count;
   logic [IDX_W-1:0]      idx_next;
   logic [IDX_W-1:0]      req_idx;
   logic                  req_in_range;
   cmd_type               req_cmd;

   ptst_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_period = ram_rd_data[ENTRY_W-1:TIMER_W];
   assign rd_count = ram_rd_data[TIMER_W-1:0];
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
   assign req_idx = req_ch.slot[IDX_W-1:0];
   assign req_in_range = ({1'b0, req_ch.slot} < (SLOT_W + 1)'(SLOT_COUNT));
   assign req_cmd = cmd_type'(req_ch.command);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.result_slot = rsp_slot_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.pending_mask = rsp_mask_ff;

   always_comb begin
      state_in = state_ff;
      active_in = active_ff;
      pending_in = pending_ff;
      probe_start_in = probe_start_ff;
      idx_in = idx_ff;
      wb_vld_in = 1'b0;
      wb_addr_in = wb_addr_ff;
      period_in = period_ff;
      res_slot_in = res_slot_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_slot_in = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mask_in = rsp_mask_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = wb_addr_ff;
      ram_wr_data = '0;

      // tick write-back of the entry read last cycle
      if (wb_vld_ff && active_ff[wb_addr_ff]) begin
         ram_wr_en = 1'b1;
         if (rd_count <= TIMER_W'(1)) begin
            pending_in[wb_addr_ff] = 1'b1;
            ram_wr_data = {rd_period, rd_period};
         end else begin
            ram_wr_data = {rd_period, rd_count - TIMER_W'(1)};
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               period_in = req_ch.period;
               res_slot_in = req_ch.slot;
               status_in = STATUS_OK;
               unique case (req_cmd)
                  CMD_TICK: begin
                     idx_in = '0;
                     state_in = ST_TICK;
                  end
                  CMD_REGISTER: begin
                     idx_in = probe_start_ff;
                     state_in = ST_PROBE;
                  end
                  CMD_REMOVE, CMD_ACK: begin
                     state_in = ST_RESP;
                     if (!req_in_range || !active_ff[req_idx]) begin
                        status_in = STATUS_INACTIVE;
                     end else begin
                        pending_in[req_idx] = 1'b0;
                        if (req_cmd == CMD_REMOVE) begin
                           active_in[req_idx] = 1'b0;
                        end
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            wb_vld_in = 1'b1;
            wb_addr_in = idx_ff;
            idx_in = idx_next;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_PROBE: begin
            if (!active_ff[idx_ff]) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = idx_ff;
               ram_wr_data = {period_ff, period_ff};
               active_in[idx_ff] = 1'b1;
               pending_in[idx_ff] = 1'b0;
               res_slot_in = SLOT_W'(idx_ff);
               probe_start_in = (probe_start_ff == LAST_IDX) ? '0
                                                             : probe_start_ff + IDX_W'(1);
               state_in = ST_RESP;
            end else begin
               idx_in = idx_next;
               if (idx_next == probe_start_ff) begin
                  status_in = STATUS_FULL;
                  res_slot_in = '0;
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in = res_slot_ff;
               rsp_status_in = status_ff;
               rsp_mask_in = MASK_W'(pending_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= '0;
         pending_ff <= '0;
         probe_start_ff <= '0;
         wb_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         active_ff <= active_in;
         pending_ff <= pending_in;
         probe_start_ff <= probe_start_in;
         wb_vld_ff <= wb_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      wb_addr_ff <= wb_addr_in;
      period_ff <= period_in;
      res_slot_ff <= res_slot_in;
      status_ff <= status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   a_pending_needs_active: assert property (@(posedge clock) disable iff (reset)
      (pending_ff & ~active_ff) == '0)
      else $error("pending flag on inactive slot");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start work");

   a_wb_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      wb_vld_ff |-> (state_ff == ST_TICK || state_ff == ST_DRAIN))
      else $error("tick write-back outside sweep");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |-> (rsp_slot_ff == '0))
      else $error("table full word with nonzero slot");

   a_rsp_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_RESP))
      else $error("result overwritten while stalled");

endmodule

FILE: tb/sv/periodic_timer_slot_table_checker.sv
`timescale 1ns / 1ps

module periodic_timer_slot_table_checker
   import ptst_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ptst_req_if  req_ch,
   ptst_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   words_in_flight
);

   typedef struct packed {
      logic [SLOT_W-1:0] result_slot;
      status_type        status;
      logic [MASK_W-1:0] pending_mask;
   } timer_word_type;

   logic               slot_active    [SLOT_COUNT];
   logic [TIMER_W-1:0] slot_period    [SLOT_COUNT];
   logic [TIMER_W-1:0] slot_countdown [SLOT_COUNT];
   logic               slot_pending   [SLOT_COUNT];
   int                 probe_start;

   timer_word_type expected_words [$];
   timer_word_type oldest;
   int             fail_total = 0;
   int             queued_count = 0;

   assign mismatch_count  = fail_total;
   assign words_in_flight = queued_count;

   function automatic timer_word_type apply_timer_command(cmd_type cmd,
                                                          logic [TIMER_W-1:0] period,
                                                          logic [SLOT_W-1:0] slot);
      timer_word_type word;
      int             start;
      int             s;
      bit             found;
      word.result_slot  = slot;
      word.status       = STATUS_OK;
      word.pending_mask = '0;
      found = 1'b0;
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_active[i]) begin
                  if (slot_countdown[i] <= TIMER_W'(1)) begin
                     slot_pending[i]   = 1'b1;
                     slot_countdown[i] = slot_period[i];
                  end else begin
                     slot_countdown[i] = slot_countdown[i] - TIMER_W'(1);
                  end
               end
            end
         end
         CMD_REGISTER: begin
            start = probe_start % SLOT_COUNT;
            for (int i = 0; i < SLOT_COUNT && !found; i++) begin
               s = (start + i) % SLOT_COUNT;
               if (!slot_active[s]) begin
                  slot_active[s]    = 1'b1;
                  slot_period[s]    = period;
                  slot_countdown[s] = period;
                  slot_pending[s]   = 1'b0;
                  word.result_slot  = SLOT_W'(s);
                  found = 1'b1;
               end
            end
            if (found) begin
               probe_start = (probe_start % SLOT_COUNT + 1) % SLOT_COUNT;
            end else begin
               word.status      = STATUS_FULL;
               word.result_slot = '0;
            end
         end
         default: begin
            if (slot >= SLOT_COUNT || !slot_active[slot]) begin
               word.status = STATUS_INACTIVE;
            end else if (cmd == CMD_REMOVE) begin
               slot_active[slot]    = 1'b0;
               slot_period[slot]    = '0;
               slot_countdown[slot] = '0;
               slot_pending[slot]   = 1'b0;
            end else begin
               slot_pending[slot] = 1'b0;
            end
         end
      endcase
      for (int i = 0; i < SLOT_COUNT && i < MASK_W; i++) begin
         if (slot_pending[i]) word.pending_mask[i] = 1'b1;
      end
      return word;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_active[i]    = 1'b0;
            slot_period[i]    = '0;
            slot_countdown[i] = '0;
            slot_pending[i]   = 1'b0;
         end
         probe_start = 0;
         expected_words.delete();
      end else begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            expected_words.push_back(apply_timer_command(cmd_type'(req_ch.command),
                                                         req_ch.period, req_ch.slot));
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: result_slot %0d status %0d pending_mask %h",
                      rsp_ch.result_slot, rsp_ch.status, rsp_ch.pending_mask);
               fail_total++;
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_ch.result_slot !== oldest.result_slot) begin
                  $error("result_slot: expected %0d, actual %0d",
                         oldest.result_slot, rsp_ch.result_slot);
                  fail_total++;
               end
               if (rsp_ch.status !== oldest.status) begin
                  $error("status: expected %0d, actual %0d", oldest.status, rsp_ch.status);
                  fail_total++;
               end
               if (rsp_ch.pending_mask !== oldest.pending_mask) begin
                  $error("pending_mask: expected %h, actual %h",
                         oldest.pending_mask, rsp_ch.pending_mask);
                  fail_total++;
               end
            end
         end
      end
      queued_count <= expected_words.size();
   end

endmodule

FILE: tb/sv/periodic_timer_slot_table_tb.sv
`timescale 1ns / 1ps

module periodic_timer_slot_table_tb;
   import ptst_pkg::*;

   localparam int RANDOM_WORDS = 900;
   localparam int TAIL_START   = 825;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock;
   logic reset;
   logic tail_phase;
   int   words_sent = 0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   words_in_flight;

   ptst_req_if req_ch ();
   ptst_rsp_if rsp_ch ();

   periodic_timer_slot_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   periodic_timer_slot_table_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   assign tail_phase = (words_sent >= TAIL_START);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_timer_slot_table_tb NOT OK");
         $finish;
      end
   end

   task automatic offer_command(cmd_type cmd, logic [15:0] period, logic [3:0] slot);
      int gap;
      if (!tail_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.period  <= period;
      req_ch.slot    <= slot;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      words_sent++;
   endtask

   // receiver: random stalls, one long hold-off so the table backs up its input
   initial begin : rsp_side
      int stall;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && words_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      int          r;
      int          pick;
      cmd_type     cmd;
      logic [15:0] period;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_TICK;
      req_ch.period  <= '0;
      req_ch.slot    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table: acknowledge and remove find nothing
      offer_command(CMD_ACK, 16'hFFFF, 4'd0);
      offer_command(CMD_REMOVE, 16'h0000, 4'd15);
      offer_command(CMD_REGISTER, 16'd0, 4'($urandom_range(0, 15)));
      offer_command(CMD_REGISTER, 16'd1, 4'($urandom_range(0, 15)));
      offer_command(CMD_REGISTER, 16'hFFFF, 4'($urandom_range(0, 15)));
      offer_command(CMD_REGISTER, 16'd2, 4'($urandom_range(0, 15)));
      repeat (3) offer_command(CMD_TICK, 16'($urandom), 4'($urandom_range(0, 15)));
      for (int i = 0; i < 12; i++) begin
         offer_command(CMD_REGISTER, 16'(i + 3), 4'($urandom_range(0, 15)));
      end
      // table full
      offer_command(CMD_REGISTER, 16'h5A5A, 4'd9);
      offer_command(CMD_ACK, 16'($urandom), 4'd0);
      offer_command(CMD_ACK, 16'($urandom), 4'd1);
      offer_command(CMD_REMOVE, 16'($urandom), 4'd2);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         r    = $urandom_range(0, 99);
         pick = $urandom_range(0, 9);
         if (r < 40) cmd = CMD_TICK;
         else if (r < 62) cmd = CMD_REGISTER;
         else if (r < 80) cmd = CMD_REMOVE;
         else cmd = CMD_ACK;
         if (pick < 7) period = 16'($urandom_range(0, 6));
         else if (pick < 9) period = 16'($urandom_range(0, 300));
         else period = 16'($urandom_range(0, 65535));
         offer_command(cmd, period, 4'($urandom_range(0, 15)));
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("periodic_timer_slot_table_tb OK");
      end else begin
         $display("periodic_timer_slot_table_tb NOT OK");
      end
      $finish;
   end

endmodule
